// ----- design/cursor_sequence_buffer_assert.svh -----
// Assertion macros for the cursor sequence buffer.
`ifndef CURSOR_SEQUENCE_BUFFER_ASSERT_SVH
`define CURSOR_SEQUENCE_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
`define CSB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csb: check failed");
`define CSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csb: check failed");
`else
`define CSB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define CSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/csb_pkg.sv -----
package csb_pkg;

  localparam int CAPACITY_DEF    = 32;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CNT_W_DEF       = $clog2(CAPACITY_DEF + 1);

  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ATTACH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_CURRENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;

  typedef enum logic [2:0] {
    OP_START,
    OP_ADVANCE,
    OP_INSERT,
    OP_ATTACH,
    OP_REMOVE,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [DATA_W-1:0]   value;
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SHIFT,
    BK_PLACE,
    BK_READ,
    BK_RESP
  } back_state_t;

endpackage

// ----- design/csb_if.sv -----
interface csb_in_if;
  logic                          valid;
  logic                          ready;
  logic [csb_pkg::CMD_W-1:0]     command;
  logic [csb_pkg::DATA_W-1:0]    entry_value;

  modport source (output valid, command, entry_value, input ready);
  modport sink   (input valid, command, entry_value, output ready);
endinterface

interface csb_out_if #(
  parameter int CNT_W = csb_pkg::CNT_W_DEF
);
  logic                          valid;
  logic                          ready;
  logic [csb_pkg::STATUS_W-1:0]  status;
  logic [CNT_W-1:0]              item_count;
  logic                          has_current;
  logic [csb_pkg::DATA_W-1:0]    current_value;

  modport source (output valid, status, item_count, has_current, current_value, input ready);
  modport sink   (input valid, status, item_count, has_current, current_value, output ready);
endinterface

// ----- design/csb_front.sv -----
module csb_front (
  csb_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            q_push,
  output csb_pkg::op_t    q_push_op
);

  always_comb begin
    in_ch.ready           = !q_full;
    q_push                = in_ch.valid && !q_full;
    q_push_op.value       = in_ch.entry_value;
    unique case (in_ch.command)
      csb_pkg::CMD_START:   q_push_op.kind = csb_pkg::OP_START;
      csb_pkg::CMD_ADVANCE: q_push_op.kind = csb_pkg::OP_ADVANCE;
      csb_pkg::CMD_INSERT:  q_push_op.kind = csb_pkg::OP_INSERT;
      csb_pkg::CMD_ATTACH:  q_push_op.kind = csb_pkg::OP_ATTACH;
      csb_pkg::CMD_REMOVE:  q_push_op.kind = csb_pkg::OP_REMOVE;
      default:              q_push_op.kind = csb_pkg::OP_NOP;
    endcase
  end

endmodule

// ----- design/csb_queue.sv -----
module csb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  csb_pkg::op_t    push_op,
  output logic            full,
  output logic            q_valid,
  output csb_pkg::op_t    q_op,
  input  logic            pop
);

  localparam logic [csb_pkg::Q_CNT_W-1:0] DepthC = csb_pkg::Q_CNT_W'(csb_pkg::QUEUE_DEPTH);
  localparam logic [csb_pkg::Q_PTR_W-1:0] LastC  =
    csb_pkg::Q_PTR_W'(csb_pkg::QUEUE_DEPTH - 1);

  csb_pkg::op_t                   slot_r [csb_pkg::QUEUE_DEPTH];
  logic [csb_pkg::Q_PTR_W-1:0]    wp_r, wp_nxt;
  logic [csb_pkg::Q_PTR_W-1:0]    rp_r, rp_nxt;
  logic [csb_pkg::Q_CNT_W-1:0]    count_r, count_nxt;

  always_comb begin
    full      = (count_r == DepthC);
    q_valid   = (count_r != '0);
    q_op      = slot_r[rp_r];
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    count_nxt = count_r;
    if (push) begin
      wp_nxt = (wp_r == LastC) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == LastC) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_op;
    end
  end

endmodule

// ----- design/csb_back.sv -----
module csb_back #(
  parameter int CAPACITY    = csb_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = csb_pkg::VALUE_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  csb_pkg::op_t    q_op,
  output logic            q_pop,
  csb_out_if.source       out_ch
);

  localparam int CntW   = $clog2(CAPACITY + 1);
  localparam int IdxW   = $clog2(CAPACITY);
  localparam int StoreW = (VALUE_WIDTH < csb_pkg::DATA_W) ? VALUE_WIDTH : csb_pkg::DATA_W;
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);
  localparam logic [CntW-1:0] One  = CntW'(1);

  csb_pkg::back_state_t             state_r, state_nxt;
  logic [CntW-1:0]                  total_r, total_nxt;
  logic [CntW-1:0]                  cursor_r, cursor_nxt;
  logic [CntW-1:0]                  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]                  cnt_r, cnt_nxt;
  logic                             up_r, up_nxt;
  logic                             pend_r, pend_nxt;
  logic [IdxW-1:0]                  pend_addr_r, pend_addr_nxt;
  logic                             place_r, place_nxt;
  logic [StoreW-1:0]                val_r, val_nxt;
  logic [csb_pkg::STATUS_W-1:0]     st_r, st_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [csb_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [CntW-1:0]                  out_count_r, out_count_nxt;
  logic                             out_has_r, out_has_nxt;
  logic [csb_pkg::DATA_W-1:0]       out_value_r, out_value_nxt;

  logic [StoreW-1:0]                mem [CAPACITY];
  logic [StoreW-1:0]                rd_data_r;
  logic [IdxW-1:0]                  rd_addr;
  logic                             mem_we;
  logic [IdxW-1:0]                  mem_wa;
  logic [StoreW-1:0]                mem_wd;

  logic                             has;
  logic                             full;
  logic [CntW-1:0]                  pos;
  logic [CntW-1:0]                  wr_tgt;

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    cursor_nxt     = cursor_r;
    rd_ptr_nxt     = rd_ptr_r;
    cnt_nxt        = cnt_r;
    up_nxt         = up_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    place_nxt      = place_r;
    val_nxt        = val_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_has_nxt    = out_has_r;
    out_value_nxt  = out_value_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    rd_addr        = cursor_r[IdxW-1:0];
    has            = (cursor_r < total_r);
    full           = (total_r >= CapC);
    pos            = '0;
    wr_tgt         = up_r ? (rd_ptr_r + One) : (rd_ptr_r - One);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      csb_pkg::BK_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop     = 1'b1;
          val_nxt   = StoreW'(q_op.value);
          st_nxt    = csb_pkg::ST_OK;
          pend_nxt  = 1'b0;
          state_nxt = csb_pkg::BK_READ;
          unique case (q_op.kind)
            csb_pkg::OP_START: begin
              cursor_nxt = '0;
            end
            csb_pkg::OP_ADVANCE: begin
              if (!has) begin
                st_nxt = csb_pkg::ST_NO_CURRENT;
              end else begin
                cursor_nxt = cursor_r + One;
              end
            end
            csb_pkg::OP_INSERT, csb_pkg::OP_ATTACH: begin
              if (full) begin
                st_nxt = csb_pkg::ST_FULL;
              end else begin
                if (q_op.kind == csb_pkg::OP_INSERT) begin
                  pos = has ? cursor_r : '0;
                end else begin
                  pos = has ? (cursor_r + One) : total_r;
                end
                cursor_nxt = pos;
                total_nxt  = total_r + One;
                rd_ptr_nxt = total_r - One;
                cnt_nxt    = total_r - pos;
                up_nxt     = 1'b1;
                place_nxt  = 1'b1;
                state_nxt  = csb_pkg::BK_SHIFT;
              end
            end
            csb_pkg::OP_REMOVE: begin
              if (!has) begin
                st_nxt = csb_pkg::ST_NO_CURRENT;
              end else begin
                total_nxt  = total_r - One;
                rd_ptr_nxt = cursor_r + One;
                cnt_nxt    = total_r - cursor_r - One;
                up_nxt     = 1'b0;
                place_nxt  = 1'b0;
                state_nxt  = csb_pkg::BK_SHIFT;
              end
            end
            default: ;
          endcase
        end
      end
      csb_pkg::BK_SHIFT: begin
        // One entry is read per cycle and written one place over on the next.
        rd_addr = rd_ptr_r[IdxW-1:0];
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = pend_addr_r;
          mem_wd = rd_data_r;
        end
        if (cnt_r != '0) begin
          cnt_nxt       = cnt_r - One;
          pend_nxt      = 1'b1;
          pend_addr_nxt = wr_tgt[IdxW-1:0];
          rd_ptr_nxt    = up_r ? (rd_ptr_r - One) : (rd_ptr_r + One);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = place_r ? csb_pkg::BK_PLACE : csb_pkg::BK_READ;
        end
      end
      csb_pkg::BK_PLACE: begin
        mem_we         = 1'b1;
        mem_wa         = cursor_r[IdxW-1:0];
        mem_wd         = val_r;
        out_valid_nxt  = 1'b1;
        out_status_nxt = st_r;
        out_count_nxt  = total_r;
        out_has_nxt    = 1'b1;
        out_value_nxt  = csb_pkg::DATA_W'(val_r);
        state_nxt      = csb_pkg::BK_IDLE;
      end
      csb_pkg::BK_READ: begin
        state_nxt = csb_pkg::BK_RESP;
      end
      csb_pkg::BK_RESP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = st_r;
        out_count_nxt  = total_r;
        out_has_nxt    = has;
        out_value_nxt  = has ? csb_pkg::DATA_W'(rd_data_r) : '0;
        state_nxt      = csb_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = csb_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csb_pkg::BK_IDLE;
      total_r     <= '0;
      cursor_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      cursor_r    <= cursor_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    cnt_r        <= cnt_nxt;
    up_r         <= up_nxt;
    pend_addr_r  <= pend_addr_nxt;
    place_r      <= place_nxt;
    val_r        <= val_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_has_r    <= out_has_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.item_count    = out_count_r;
  assign out_ch.has_current   = out_has_r;
  assign out_ch.current_value = out_value_r;

endmodule

// ----- design/cursor_sequence_buffer.sv -----
// Ordered store of up to CAPACITY values with a cursor. Each input beat carries a
// command (start, advance, insert before the cursor, attach after it, remove the
// current item) and a value; each gives exactly one result beat with a status, the
// item count, whether a current item exists and its value. A small queue takes input
// beats while the execution side is busy or a result waits to be taken. Insert and
// attach shift every entry from the new place onward up by one before the value is
// written; remove shifts every entry behind the current item down by one. The shift
// is paced by the value memory, which has one read and one write port and moves one
// entry per cycle.
`include "cursor_sequence_buffer_assert.svh"

module cursor_sequence_buffer #(
  parameter int CAPACITY    = csb_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = csb_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  csb_in_if.sink     in_ch,
  csb_out_if.source  out_ch
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);

  logic           q_full;
  logic           q_push;
  csb_pkg::op_t   q_push_op;
  logic           q_valid;
  csb_pkg::op_t   q_op;
  logic           q_pop;

  csb_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_push_op (q_push_op)
  );

  csb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_push_op),
    .full    (q_full),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (q_pop)
  );

  csb_back #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  `CSB_ASSERT_IMPLY(a_pop_needs_item, clk, rst_n, q_pop, q_valid)
  `CSB_ASSERT_IMPLY(a_full_at_capacity, clk, rst_n, out_ch.valid && out_ch.status == csb_pkg::ST_FULL, out_ch.item_count == CapC)
  `CSB_ASSERT_IMPLY(a_no_current_zero, clk, rst_n, out_ch.valid && !out_ch.has_current, out_ch.current_value == '0)
  `CSB_ASSERT_NEXT(a_one_result_in_flight, clk, rst_n, out_ch.valid && out_ch.ready, !out_ch.valid)

endmodule

// ----- tb/tb_cursor_sequence_buffer.sv -----
`timescale 1ns / 1ps

module tb_cursor_sequence_buffer;

  localparam int SEQ_CAPACITY = csb_pkg::CAPACITY_DEF;
  localparam int MAX_REPORTS  = 10;
  localparam logic [csb_pkg::CMD_W-1:0] CMD_UNKNOWN_FIRST = 3'd5;

  typedef struct packed {
    logic [csb_pkg::STATUS_W-1:0]  status;
    logic [csb_pkg::CNT_W_DEF-1:0] item_count;
    logic                          has_current;
    logic [csb_pkg::DATA_W-1:0]    current_value;
  } seq_result_t;

  typedef enum {MOOD_GROW, MOOD_SHRINK, MOOD_WALK} mood_t;

  logic clk = 1'b0;
  logic rst_n;

  csb_in_if  in_ch ();
  csb_out_if out_ch ();

  cursor_sequence_buffer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [csb_pkg::DATA_W-1:0] seq_items[$];
  int                         seq_cursor;
  seq_result_t                expected_results[$];
  int                         error_count;
  int                         send_idle_pct;
  int                         recv_idle_pct;
  int                         recv_hold_cycles;

  always #1 clk = ~clk;

  function automatic seq_result_t step_sequence(input logic [csb_pkg::CMD_W-1:0] cmd,
                                                input logic [csb_pkg::DATA_W-1:0] val);
    seq_result_t r;
    bit          had;
    had      = seq_cursor < seq_items.size();
    r.status = csb_pkg::ST_OK;
    case (cmd)
      csb_pkg::CMD_START: begin
        seq_cursor = 0;
      end
      csb_pkg::CMD_ADVANCE: begin
        if (!had) r.status = csb_pkg::ST_NO_CURRENT;
        else seq_cursor++;
      end
      csb_pkg::CMD_INSERT, csb_pkg::CMD_ATTACH: begin
        if (seq_items.size() >= SEQ_CAPACITY) begin
          r.status = csb_pkg::ST_FULL;
        end else if (!had) begin
          if (cmd == csb_pkg::CMD_INSERT) seq_cursor = 0;
          else seq_cursor = seq_items.size();
          seq_items.insert(seq_cursor, val);
        end else begin
          if (cmd == csb_pkg::CMD_ATTACH) seq_cursor++;
          seq_items.insert(seq_cursor, val);
        end
      end
      csb_pkg::CMD_REMOVE: begin
        if (!had) r.status = csb_pkg::ST_NO_CURRENT;
        else seq_items.delete(seq_cursor);
      end
      default: begin
      end
    endcase
    r.item_count    = csb_pkg::CNT_W_DEF'(seq_items.size());
    r.has_current   = seq_cursor < seq_items.size();
    r.current_value = r.has_current ? seq_items[seq_cursor] : '0;
    return r;
  endfunction

  function automatic logic [csb_pkg::CMD_W-1:0] pick_command(input mood_t mood);
    int                        roll;
    logic [csb_pkg::CMD_W-1:0] cmd;
    roll = $urandom_range(99);
    case (mood)
      MOOD_GROW: begin
        if (roll < 45) cmd = csb_pkg::CMD_INSERT;
        else if (roll < 85) cmd = csb_pkg::CMD_ATTACH;
        else if (roll < 92) cmd = csb_pkg::CMD_ADVANCE;
        else if (roll < 96) cmd = csb_pkg::CMD_START;
        else cmd = csb_pkg::CMD_REMOVE;
      end
      MOOD_SHRINK: begin
        if (roll < 60) cmd = csb_pkg::CMD_REMOVE;
        else if (roll < 75) cmd = csb_pkg::CMD_START;
        else if (roll < 88) cmd = csb_pkg::CMD_ADVANCE;
        else if (roll < 94) cmd = csb_pkg::CMD_INSERT;
        else cmd = csb_pkg::CMD_ATTACH;
      end
      default: begin
        if (roll < 14) cmd = csb_pkg::CMD_START;
        else if (roll < 50) cmd = csb_pkg::CMD_ADVANCE;
        else if (roll < 65) cmd = csb_pkg::CMD_INSERT;
        else if (roll < 80) cmd = csb_pkg::CMD_ATTACH;
        else cmd = csb_pkg::CMD_REMOVE;
      end
    endcase
    if ($urandom_range(99) < 4) begin
      cmd = CMD_UNKNOWN_FIRST + csb_pkg::CMD_W'($urandom_range(2));
    end
    return cmd;
  endfunction

  task automatic send_command(input logic [csb_pkg::CMD_W-1:0] cmd,
                              input logic [csb_pkg::DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.entry_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(step_sequence(cmd, val));
    @(negedge clk);
  endtask

  task automatic wait_drained;
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed;
    int k;
    send_idle_pct = 11;
    recv_idle_pct = 80;
    send_command(csb_pkg::CMD_ADVANCE, '1);
    send_command(csb_pkg::CMD_REMOVE, '1);
    send_command(csb_pkg::CMD_START, '0);
    send_command(csb_pkg::CMD_INSERT, '0);
    send_command(csb_pkg::CMD_ADVANCE, '0);
    send_command(csb_pkg::CMD_ATTACH, '1);
    send_command(csb_pkg::CMD_INSERT, 32'h0000_0001);
    send_command(csb_pkg::CMD_ATTACH, 32'h8000_0000);
    send_command(csb_pkg::CMD_ADVANCE, '0);
    send_command(csb_pkg::CMD_ADVANCE, '0);
    send_command(csb_pkg::CMD_REMOVE, '0);
    send_command(csb_pkg::CMD_INSERT, 32'h5555_AAAA);
    send_command(csb_pkg::CMD_START, '1);
    for (k = 0; k < 3; k++) send_command(CMD_UNKNOWN_FIRST + csb_pkg::CMD_W'(k), '1);
    send_command(csb_pkg::CMD_ADVANCE, '0);
    send_command(csb_pkg::CMD_REMOVE, '0);
    send_command(csb_pkg::CMD_START, '0);
    repeat (5) send_command(csb_pkg::CMD_REMOVE, '0);
    wait_drained();
  endtask

  // The receiver holds off at the start so the block backs up to its input, then the store is filled past capacity.
  task automatic test_full_store;
    int k;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    recv_hold_cycles = 400;
    send_command(csb_pkg::CMD_START, '0);
    for (k = 0; k < SEQ_CAPACITY + 4; k++) send_command(csb_pkg::CMD_ATTACH, $urandom);
    send_command(csb_pkg::CMD_INSERT, $urandom);
    send_command(csb_pkg::CMD_START, '0);
    send_command(csb_pkg::CMD_INSERT, $urandom);
    send_command(csb_pkg::CMD_ADVANCE, '0);
    send_command(csb_pkg::CMD_REMOVE, '0);
    send_command(csb_pkg::CMD_INSERT, $urandom);
    wait_drained();
  endtask

  task automatic test_random(input int item_goal, input int send_pct, input int recv_pct);
    int                         counted;
    int                         mood_left;
    mood_t                      mood;
    logic [csb_pkg::CMD_W-1:0]  cmd;
    logic [csb_pkg::DATA_W-1:0] val;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    counted       = 0;
    mood_left     = 0;
    mood          = MOOD_WALK;
    while (counted < item_goal) begin
      if (mood_left == 0) begin
        mood      = mood_t'($urandom_range(2));
        mood_left = $urandom_range(60, 20);
      end
      mood_left--;
      cmd = pick_command(mood);
      case ($urandom_range(9))
        0: val = '0;
        1: val = '1;
        default: val = $urandom;
      endcase
      send_command(cmd, val);
      counted++;
    end
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (recv_hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      recv_hold_cycles--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    seq_result_t got;
    seq_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.status, out_ch.item_count, out_ch.has_current, out_ch.current_value};
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result beat with nothing expected: status %0d count %0d has %0b value %h",
                   $realtime, got.status, got.item_count, got.has_current, got.current_value);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.item_count !== want.item_count ||
            got.has_current !== want.has_current || got.current_value !== want.current_value)
        begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: expected status %0d count %0d has %0b value %h", $realtime,
                     want.status, want.item_count, want.has_current, want.current_value);
            $display("%0t:   actual status %0d count %0d has %0b value %h", $realtime,
                     got.status, got.item_count, got.has_current, got.current_value);
          end
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    error_count       = 0;
    seq_cursor        = 0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    recv_hold_cycles  = 0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = csb_pkg::CMD_START;
    in_ch.entry_value = '0;
    out_ch.ready      = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_store();
    test_random(460, 11, 80);
    test_random(460, 80, 11);
    test_random(463, 0, 0);
    wait_drained();
    repeat (SEQ_CAPACITY + 16) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/csb_pkg.sv
design/csb_if.sv
design/csb_front.sv
design/csb_queue.sv
design/csb_back.sv
design/cursor_sequence_buffer.sv
tb/tb_cursor_sequence_buffer.sv
